// ----- src/lbs_pkg.sv -----
package lbs_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_RIGID  = 2'd1,
    MODE_FIRST  = 2'd2,
    MODE_ADD    = 2'd3
  } mode_e;

  localparam int unsigned NumElems = 12;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [16:0]        weight;
    logic [11:0]        dest_index;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        out_index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       capture;    // latch the vertex transaction
    logic       load_elem;  // write the matrix element from the input
    logic [1:0] row;
    logic [1:0] col;
    logic       mul_step;   // product for row/col
    logic       acc_init;   // sum = translation plus half LSB
    logic       acc_add;    // sum += previous product
    logic       row_done;   // round/saturate the row sum
    logic       wgt_step;   // weight multiply for row
    logic       wgt_done;   // saturate weighted value for row
    logic       acc_rd;     // read the destination slot
    logic       acc_step;   // add slot value for row
    logic       write_back;
  } lbs_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x, output logic f);
    logic signed [31:0] r;
    f = 1'b0;
    r = x[31:0];
    if (x > 50'sd2147483647) begin
      r = 32'sh7fffffff;
      f = 1'b1;
    end else if (x < -50'sd2147483648) begin
      r = 32'sh80000000;
      f = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- src/linear_blend_skinning.sv -----
// Linear blend skinning engine.
// Input channel in_valid_i/in_stall_o carries in_item_t transactions.
// Mode 0 writes one element of the bone matrix and gives no result; a load
// is taken every cycle while the block is idle. Element indexes 12..15 are
// ignored.
// Modes 1..3 transform a vertex by the 3x4 matrix, optionally weight it,
// optionally add it to the stored destination slot, and emit one out_item_t
// transaction on out_valid_o/out_stall_i. Slots >= MaxDests give no result.
// One vertex is processed at a time; the matrix products of each row share
// a single 32x32 multiplier and are followed by a rounding step. After the
// result handshake the controller returns to idle before the next input is
// taken, so a new vertex is not accepted until the last result is taken.
// Reset clears control state and sets the bone matrix to zero; the slot
// memory is not cleared and a slot must be written before it is added to.
// While the receiver stalls the result is held stable and input stalls.
module linear_blend_skinning #(
  parameter int unsigned MaxDests = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lbs_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lbs_pkg::out_item_t out_data_o
);
  import lbs_pkg::*;

  lbs_cmd_t cmd;
  logic     rigid, add, drop;

  lbs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .in_mode_i(in_data_i.mode), .out_valid_o, .out_stall_i,
    .mode_rigid_i(rigid), .mode_add_i(add), .drop_i(drop), .cmd_o(cmd)
  );

  lbs_datapath #(.MaxDests(MaxDests)) u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .cmd_i(cmd),
    .mode_rigid_o(rigid), .mode_add_o(add), .drop_o(drop), .res_o(out_data_o)
  );

endmodule

// ----- src/lbs_datapath.sv -----
module lbs_datapath #(
  parameter int unsigned MaxDests = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lbs_pkg::in_item_t  in_i,
  input  lbs_pkg::lbs_cmd_t  cmd_i,
  output logic               mode_rigid_o,
  output logic               mode_add_o,
  output logic               drop_o,
  output lbs_pkg::out_item_t res_o
);
  import lbs_pkg::*;

  localparam int unsigned AW = $clog2(MaxDests);

  in_item_t           item_q;
  logic signed [31:0] mat_q [NumElems];
  logic signed [63:0] prod_q;
  logic signed [65:0] acc_q;   // exact row sum in Q34.32 plus half LSB
  logic signed [31:0] v_q [3];
  logic signed [49:0] wprod_q;
  logic               flag_q;
  logic [95:0]        mem [MaxDests];
  logic [95:0]        rd_q;
  logic [AW-1:0]      addr;
  logic signed [31:0] pc;
  logic signed [31:0] rd_sel;
  logic signed [65:0] sh_row;
  logic signed [31:0] v_rnd, v_wgt, v_acc;
  logic               f_rnd, f_wgt, f_acc;

  assign mode_rigid_o = item_q.mode == MODE_RIGID;
  assign mode_add_o   = item_q.mode == MODE_ADD;
  assign drop_o       = 32'(in_i.dest_index) >= 32'(MaxDests);
  assign addr         = AW'(item_q.dest_index);

  always_comb begin
    case (cmd_i.col)
      2'd0:    pc = item_q.pos_x;
      2'd1:    pc = item_q.pos_y;
      default: pc = item_q.pos_z;
    endcase
  end

  always_comb begin
    case (cmd_i.row)
      2'd0:    rd_sel = rd_q[31:0];
      2'd1:    rd_sel = rd_q[63:32];
      default: rd_sel = rd_q[95:64];
    endcase
  end

  always_comb begin
    sh_row = acc_q >>> 16;
    v_rnd  = sat32(sh_row[49:0], f_rnd);
    v_wgt  = sat32(wprod_q, f_wgt);
    v_acc  = sat32(50'(rd_sel) + 50'(v_q[cmd_i.row]), f_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= '{default: '0};
    end else if (cmd_i.load_elem && in_i.element_index < 4'(NumElems)) begin
      mat_q[in_i.element_index] <= in_i.element_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture)
      item_q <= in_i;
    if (cmd_i.mul_step)
      prod_q <= mat_q[{cmd_i.row, cmd_i.col}] * pc;
    if (cmd_i.acc_init)
      acc_q <= (66'(mat_q[{cmd_i.row, 2'd3}]) <<< 16) + 66'sd32768;
    else if (cmd_i.acc_add)
      acc_q <= acc_q + 66'(prod_q);
    if (cmd_i.wgt_step)
      wprod_q <= (v_q[cmd_i.row] * signed'({1'b0, item_q.weight}) + 50'sd32768) >>> 16;
    if (cmd_i.capture) begin
      flag_q <= 1'b0;
    end else if (cmd_i.row_done) begin
      v_q[cmd_i.row] <= v_rnd;
      flag_q <= flag_q | f_rnd;
    end else if (cmd_i.wgt_done) begin
      v_q[cmd_i.row] <= v_wgt;
      flag_q <= flag_q | f_wgt;
    end else if (cmd_i.acc_step) begin
      v_q[cmd_i.row] <= v_acc;
      flag_q <= flag_q | f_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_rd)
      rd_q <= mem[addr];
    if (cmd_i.write_back)
      mem[addr] <= {v_q[2], v_q[1], v_q[0]};
  end

  assign res_o.out_index = item_q.dest_index;
  assign res_o.out_x     = v_q[0];
  assign res_o.out_y     = v_q[1];
  assign res_o.out_z     = v_q[2];
  assign res_o.saturated = flag_q;

endmodule

// ----- src/lbs_ctrl.sv -----
module lbs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        in_mode_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic              mode_rigid_i,
  input  logic              mode_add_i,
  input  logic              drop_i,
  output lbs_pkg::lbs_cmd_t cmd_o
);
  import lbs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_RND, S_WGT, S_WSAT, S_ACC, S_WB, S_OUT
  } state_e;

  state_e     state_q;
  logic [1:0] row_q, col_q;
  logic       accept;

  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    cmd_o           = '0;
    cmd_o.row       = row_q;
    cmd_o.col       = col_q;
    accept          = state_q == S_IDLE && in_valid_i;
    cmd_o.load_elem = accept && in_mode_i == MODE_LOAD;
    cmd_o.capture   = accept && in_mode_i != MODE_LOAD && !drop_i;
    case (state_q)
      S_MUL: begin
        // col 3 only folds in the last product
        cmd_o.mul_step = col_q != 2'd3;
        cmd_o.acc_init = col_q == 2'd0;
        cmd_o.acc_add  = col_q != 2'd0;
        cmd_o.acc_rd   = 1'b1;
      end
      S_RND:   cmd_o.row_done   = 1'b1;
      S_WGT:   cmd_o.wgt_step   = 1'b1;
      S_WSAT:  cmd_o.wgt_done   = 1'b1;
      S_ACC:   cmd_o.acc_step   = 1'b1;
      S_WB:    cmd_o.write_back = 1'b1;
      default: cmd_o.write_back = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q <= '0;
      col_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_o.capture) begin
            row_q <= '0;
            col_q <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (col_q == 2'd3) begin
            state_q <= S_RND;
          end else begin
            col_q <= col_q + 2'd1;
          end
        end
        S_RND: begin
          col_q <= '0;
          if (row_q == 2'd2) begin
            row_q <= '0;
            state_q <= mode_rigid_i ? S_WB : S_WGT;
          end else begin
            row_q <= row_q + 2'd1;
            state_q <= S_MUL;
          end
        end
        S_WGT: state_q <= S_WSAT;
        S_WSAT: begin
          if (mode_add_i) begin
            state_q <= S_ACC;
          end else if (row_q == 2'd2) begin
            state_q <= S_WB;
          end else begin
            row_q <= row_q + 2'd1;
            state_q <= S_WGT;
          end
        end
        S_ACC: begin
          if (row_q == 2'd2) begin
            state_q <= S_WB;
          end else begin
            row_q <= row_q + 2'd1;
            state_q <= S_WGT;
          end
        end
        S_WB: begin
          out_valid_o <= 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- verif/testbench.sv -----
module testbench;
  import lbs_pkg::*;

  class skin_scoreboard;
    logic signed [31:0] matrix[12];
    logic signed [31:0] slots[4096][3];
    bit                 written[4096];
    out_item_t          pending[$];
    int                 errors;
    int                 checked;
    int                 sat_seen;

    function new();
      foreach (matrix[i]) matrix[i] = '0;
      errors = 0;
      checked = 0;
      sat_seen = 0;
    endfunction

    static function logic signed [63:0] clamp32(input logic signed [63:0] x,
                                                inout bit f);
      if (x > 64'sd2147483647) begin
        f = 1;
        return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
        f = 1;
        return -64'sd2147483648;
      end
      return x;
    endfunction

    function void note_input(in_item_t it);
      out_item_t e;
      bit f;
      logic signed [95:0] acc;
      logic signed [63:0] v;
      logic signed [31:0] p[3];
      if (it.mode == MODE_LOAD) begin
        if (it.element_index < NumElems) matrix[it.element_index] = it.element_value;
        return;
      end
      f = 0;
      p[0] = it.pos_x;
      p[1] = it.pos_y;
      p[2] = it.pos_z;
      e.out_index = it.dest_index;
      for (int r = 0; r < 3; r++) begin
        // exact sum in Q64.32, round half up to Q16.16
        acc = 96'(matrix[r*4+3]) <<< 16;
        for (int c = 0; c < 3; c++) acc += 96'(matrix[r*4+c]) * 96'(p[c]);
        v = clamp32(64'((acc + 96'sd32768) >>> 16), f);
        if (it.mode != MODE_RIGID) begin
          acc = 96'(v) * 96'($signed({1'b0, it.weight}));
          v = clamp32(64'((acc + 96'sd32768) >>> 16), f);
        end
        if (it.mode == MODE_ADD) v = clamp32(v + 64'(slots[it.dest_index][r]), f);
        slots[it.dest_index][r] = v[31:0];
        case (r)
          0: e.out_x = v[31:0];
          1: e.out_y = v[31:0];
          default: e.out_z = v[31:0];
        endcase
      end
      e.saturated = f;
      written[it.dest_index] = 1;
      pending.push_back(e);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      checked++;
      if (got.saturated) sat_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.out_index !== e.out_index)
        $display("%0t: index expected %0d actual %0d", $time, e.out_index, got.out_index);
      if (got.out_x !== e.out_x)
        $display("%0t: x expected %0d actual %0d", $time, e.out_x, got.out_x);
      if (got.out_y !== e.out_y)
        $display("%0t: y expected %0d actual %0d", $time, e.out_y, got.out_y);
      if (got.out_z !== e.out_z)
        $display("%0t: z expected %0d actual %0d", $time, e.out_z, got.out_z);
      if (got.saturated !== e.saturated)
        $display("%0t: saturated expected %0b actual %0b", $time, e.saturated, got.saturated);
      if (got !== e) errors++;
    endfunction
  endclass

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      in_valid_i = 0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 0;
  out_item_t out_data_o;

  skin_scoreboard sb = new();
  int  send_idle = 0;
  int  recv_stall = 0;
  bit  hold_recv = 0;
  int  sent = 0;

  always #5 clk_i = ~clk_i;

  linear_blend_skinning dut (.*);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    out_stall_i <= hold_recv || ($urandom_range(99) < recv_stall);
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom());
      default: return $signed(32'($urandom_range(8 << 16)) - 32'(4 << 16));
    endcase
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(it);
    sent++;
  endtask

  task automatic load_elem(int idx, logic signed [31:0] val);
    in_item_t it;
    it = in_item_t'(163'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom()}));
    it.mode = MODE_LOAD;
    it.element_index = 4'(idx);
    it.element_value = val;
    send_item(it);
  endtask

  task automatic send_vertex(mode_e m, logic [11:0] dst, logic [16:0] w,
                             logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
    in_item_t it;
    it = in_item_t'(163'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom()}));
    if (m == MODE_ADD && !sb.written[dst]) m = MODE_FIRST;
    it.mode = m;
    it.dest_index = dst;
    it.weight = w;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    send_item(it);
  endtask

  task automatic random_bone();
    for (int i = 0; i < 12; i++)
      load_elem(i, ($urandom_range(9) == 0) ? $signed($urandom()) :
                   $signed(32'($urandom_range(4 << 16)) - 32'(2 << 16)));
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic random_phase(int n);
    logic [16:0] w;
    logic [11:0] dst;
    int          r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 4) random_bone();
      else if (r < 7) load_elem($urandom_range(15), $signed($urandom()));
      else begin
        dst = ($urandom_range(3) == 0) ? 12'($urandom()) : 12'($urandom_range(31));
        w = ($urandom_range(7) == 0) ? 17'($urandom_range(131071)) :
                                       17'($urandom_range(65536));
        send_vertex(mode_e'($urandom_range(1, 3)), dst, w,
                    rand_coord(), rand_coord(), rand_coord());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: identity, then a big scale to force clamps
    for (int i = 0; i < 12; i++) load_elem(i, (i % 5 == 0) ? 32'sh10000 : 32'sh0);
    send_vertex(MODE_RIGID, 12'd0, 17'd0, 32'sh7fffffff, 32'sh80000000, 32'sh00018000);
    send_vertex(MODE_FIRST, 12'd4095, 17'd65536, 32'sh10000, -32'sh10000, 32'sh1);
    send_vertex(MODE_ADD, 12'd4095, 17'h1ffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    send_vertex(MODE_FIRST, 12'd1, 17'd1, 32'sh8000, -32'sh8000, 32'sh18000);
    load_elem(12, 32'sh7fffffff);
    load_elem(15, 32'sh80000000);
    load_elem(0, 32'sh7fffffff);
    load_elem(3, 32'sh80000000);
    send_vertex(MODE_RIGID, 12'd2, 17'd0, 32'sh7fffffff, 32'sh0, 32'sh0);
    send_vertex(MODE_ADD, 12'd1, 17'd32768, -32'sh7fffffff, 32'sh1, 32'sh0);
    drain();

    send_idle = 0;  recv_stall = 0;  random_phase(280);
    send_idle = 59; recv_stall = 0;  random_phase(245);
    drain();
    send_idle = 0;  recv_stall = 59; random_phase(245);
    send_idle = 17; recv_stall = 17; random_phase(245);
    // long hold-off on the output while input keeps offering
    send_idle = 0;  recv_stall = 0;
    fork
      begin
        hold_recv = 1;
        repeat (300) @(posedge clk_i);
        hold_recv = 0;
      end
      random_phase(20);
    join
    random_phase(230);
    drain();

    $display("Sent %0d transactions; %0d results checked, %0d with saturation.",
             sent, sb.checked, sb.sat_seen);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
